FILE: rtl/core/rhw_pkg.sv
// ----------------------------------------------------------------------------
// rhw_pkg: shared types, constants and helpers for the RGB-to-HSV window gate
// Holds field widths, register indexes and reset values, the stage sideband
// struct, and the window test used by the gating stage.
// ----------------------------------------------------------------------------
package rhw_pkg;

	// channel and divider widths
	localparam int CH_W      = 8;
	localparam int DIV_NUM_W = 16;
	localparam int DIV_DEN_W = 8;
	localparam int RECIP_W   = DIV_NUM_W + 1;
	localparam int PROD_W    = DIV_NUM_W + RECIP_W;
	localparam int CHK_W     = DIV_NUM_W + DIV_DEN_W;
	localparam int RECIP_ONE = 2 ** DIV_NUM_W;

	// configuration registers
	localparam int NUM_WIN   = 6;
	localparam int WIN_W     = 2 * CH_W;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HUE_WIN   = 3'd0,
		REG_SAT_WIN   = 3'd1,
		REG_VAL_WIN   = 3'd2,
		REG_RED_WIN   = 3'd3,
		REG_GREEN_WIN = 3'd4,
		REG_BLUE_WIN  = 3'd5
	} cfg_reg_t;

	localparam logic [WIN_W-1:0] HUE_WIN_RST   = 16'h1530;
	localparam logic [WIN_W-1:0] SAT_WIN_RST   = 16'h3FFF;
	localparam logic [WIN_W-1:0] VAL_WIN_RST   = 16'h67FF;
	localparam logic [WIN_W-1:0] RED_WIN_RST   = 16'h00FF;
	localparam logic [WIN_W-1:0] GREEN_WIN_RST = 16'h00FF;
	localparam logic [WIN_W-1:0] BLUE_WIN_RST  = 16'h00FF;

	// hue sector offsets, one third of the circle apart
	localparam logic [CH_W-1:0] HUE_BASE_RED   = 8'd0;
	localparam logic [CH_W-1:0] HUE_BASE_GREEN = 8'd85;
	localparam logic [CH_W-1:0] HUE_BASE_BLUE  = 8'd171;

	// which channel holds the maximum (red wins ties, then green)
	typedef enum logic [1:0] {
		MAX_RED,
		MAX_GREEN,
		MAX_BLUE
	} max_sel_t;

	// per-pixel data that rides alongside the dividers
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] val;
		logic [CH_W-1:0] delta;
		max_sel_t        sel;
	} side_t;

	// stage advance enables for the divider pipeline
	typedef struct packed {
		logic a;
		logic b;
		logic c;
	} div_en_t;

	// window test: high when x falls outside the window
	function automatic logic win_fail(input logic [CH_W-1:0] x, input logic [WIN_W-1:0] win);
		logic [CH_W-1:0] left;
		logic [CH_W-1:0] right;
		logic            fail;
		left  = win[WIN_W-1:CH_W];
		right = win[CH_W-1:0];
		if (left < right) begin
			fail = (x < left) || (x > right);
		end else if (left > right) begin
			fail = (x < left) && (x > right);
		end else begin
			fail = (x != left);
		end
		return fail;
	endfunction

endpackage

FILE: rtl/core/rhw_prep.sv
// ----------------------------------------------------------------------------
// rhw_prep: channel analysis
// Finds max, min and delta of the pixel, picks the hue sector and forms the
// signed channel difference that drives the hue numerator.
// ----------------------------------------------------------------------------
module rhw_prep import rhw_pkg::*; (
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	output side_t           side,
	output logic [CH_W:0]   diff
);

	logic [CH_W-1:0] ch_max;
	logic [CH_W-1:0] ch_min;

	// max and min over the three channels
	always_comb begin
		if (red > green) begin
			ch_max = (red > blue) ? red : blue;
		end else begin
			ch_max = (green > blue) ? green : blue;
		end
		if (red < green) begin
			ch_min = (red < blue) ? red : blue;
		end else begin
			ch_min = (green < blue) ? green : blue;
		end
	end

	// sector select and difference, two's complement over CH_W+1 bits
	always_comb begin
		side.red   = red;
		side.green = green;
		side.blue  = blue;
		side.val   = ch_max;
		side.delta = ch_max - ch_min;
		if (ch_max == red) begin
			side.sel = MAX_RED;
			diff     = {1'b0, green} - {1'b0, blue};
		end else if (ch_max == green) begin
			side.sel = MAX_GREEN;
			diff     = {1'b0, blue} - {1'b0, red};
		end else begin
			side.sel = MAX_BLUE;
			diff     = {1'b0, red} - {1'b0, green};
		end
	end

endmodule

FILE: rtl/core/rhw_div.sv
// ----------------------------------------------------------------------------
// rhw_div: pipelined unsigned divider
// Three stages: reciprocal lookup, multiply by the reciprocal, then one
// back-multiply and compare that corrects the estimate by at most one.
// ----------------------------------------------------------------------------
module rhw_div import rhw_pkg::*; (
	input  logic                 clk,
	input  div_en_t              en,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic [DIV_NUM_W-1:0] quo
);

	// reciprocal ROM: ceil(2^DIV_NUM_W / d); entry zero is unused
	logic [RECIP_W-1:0] recip_rom [2**DIV_DEN_W];

	for (genvar i = 0; i < 2**DIV_DEN_W; i++) begin : g_rom
		localparam int RecipVal = (i == 0) ? 0 : ((RECIP_ONE + i - 1) / ((i == 0) ? 1 : i));
		assign recip_rom[i] = RECIP_W'(RecipVal);
	end

	logic [DIV_NUM_W-1:0] num_a;
	logic [DIV_DEN_W-1:0] den_a;
	logic [RECIP_W-1:0]   recip_a;
	logic [PROD_W-1:0]    prod_b;
	logic [DIV_NUM_W-1:0] num_b;
	logic [DIV_DEN_W-1:0] den_b;
	logic [DIV_NUM_W-1:0] est_b;
	logic [CHK_W-1:0]     chk_c;
	logic [DIV_NUM_W-1:0] quo_c;

	// stage A: table lookup
	always_ff @(posedge clk) begin
		if (en.a) begin
			num_a   <= num;
			den_a   <= den;
			recip_a <= recip_rom[den];
		end
	end

	// stage B: estimate is exact or one too high since num < 2^DIV_NUM_W
	assign prod_b = PROD_W'(num_a) * PROD_W'(recip_a);

	always_ff @(posedge clk) begin
		if (en.b) begin
			num_b <= num_a;
			den_b <= den_a;
			est_b <= prod_b[DIV_NUM_W +: DIV_NUM_W];
		end
	end

	// stage C: back-multiply and correct
	assign chk_c = CHK_W'(est_b) * CHK_W'(den_b);

	always_ff @(posedge clk) begin
		if (en.c) begin
			quo_c <= (chk_c > CHK_W'(num_b)) ? (est_b - 1'b1) : est_b;
		end
	end

	assign quo = quo_c;

endmodule

FILE: rtl/core/rhw_gate.sv
// ----------------------------------------------------------------------------
// rhw_gate: hue assembly and window gating
// Adds the sector offset to the rounded hue fraction, applies the black and
// grey cases, and tests H, S, V, R, G and B against their windows.
// ----------------------------------------------------------------------------
module rhw_gate import rhw_pkg::*; (
	input  side_t                       side,
	input  logic                        hue_neg,
	input  logic [DIV_NUM_W-1:0]        hue_quo,
	input  logic [DIV_NUM_W-1:0]        sat_quo,
	input  logic [NUM_WIN-1:0][WIN_W-1:0] win,
	output logic [CH_W-1:0]             hue,
	output logic [CH_W-1:0]             sat,
	output logic                        reject
);

	logic [CH_W-1:0] frac;
	logic [CH_W-1:0] base;

	// negative fractions come back as the complement of the magnitude quotient
	assign frac = hue_neg ? ~hue_quo[CH_W-1:0] : hue_quo[CH_W-1:0];

	always_comb begin
		case (side.sel)
			MAX_RED:   base = HUE_BASE_RED;
			MAX_GREEN: base = HUE_BASE_GREEN;
			MAX_BLUE:  base = HUE_BASE_BLUE;
			default:   base = HUE_BASE_RED;
		endcase
	end

	// black forces S to zero; black or grey forces H to zero
	always_comb begin
		sat = (side.val == '0) ? '0 : sat_quo[CH_W-1:0];
		if ((sat == '0) || (side.delta == '0)) begin
			hue = '0;
		end else begin
			hue = base + frac;
		end
	end

	// any failed window rejects the pixel
	assign reject = win_fail(hue, win[REG_HUE_WIN])
		|| win_fail(sat, win[REG_SAT_WIN])
		|| win_fail(side.val, win[REG_VAL_WIN])
		|| win_fail(side.red, win[REG_RED_WIN])
		|| win_fail(side.green, win[REG_GREEN_WIN])
		|| win_fail(side.blue, win[REG_BLUE_WIN]);

endmodule

FILE: rtl/core/rgb_to_hsv_window_gate_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_window_gate_core: RGB-to-HSV converter with window gating
// Converts each 8-bit RGB pixel to 8-bit HSV and flags it for rejection when
// any of H, S, V, R, G, B falls outside its configured window.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless a full pipeline waits on m_tready, and returns
// one result per pixel, in order. A result passes five register stages after its
// request is accepted: max/min analysis (loaded at the accepting edge), the
// three pipelined divider stages (reciprocal ROM, multiply, correction) and the
// output register. Each stage advances on its own, so s_tready drops only once
// every stage holds a pixel and m_tready is low.
// Window registers are written through the cfg port; writes to indexes past
// the last register are ignored. Write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
module rgb_to_hsv_window_gate_core import rhw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// pixel in
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [3*CH_W-1:0]    s_tdata,   // red_in, green_in, blue_in
	// result out
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [3*CH_W-1:0]    m_tdata,   // hue_out, sat_out, val_out
	output logic [0:0]           m_tuser,   // reject
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WIN_W-1:0]     cfg_data
);

	logic [NUM_WIN-1:0][WIN_W-1:0] win_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	side_t          side_in;
	logic [CH_W:0]  diff_in;
	side_t          side_s1, side_s2, side_s3, side_s4;
	logic [CH_W:0]  diff_s1;
	logic           neg_s2, neg_s3, neg_s4;

	logic [DIV_NUM_W-1:0]        sat_num;
	logic signed [DIV_NUM_W-1:0] hue_full;
	logic signed [DIV_NUM_W-1:0] hue_half;
	logic                        hue_neg;
	logic [DIV_NUM_W-1:0]        hue_mag;
	logic [DIV_NUM_W-1:0]        sat_quo;
	logic [DIV_NUM_W-1:0]        hue_quo;
	div_en_t                     div_en;

	logic [CH_W-1:0] hue_g, sat_g;
	logic            rej_g;
	logic [CH_W-1:0] hue_s5, sat_s5, val_s5;
	logic            rej_s5;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[REG_HUE_WIN]   <= HUE_WIN_RST;
			win_q[REG_SAT_WIN]   <= SAT_WIN_RST;
			win_q[REG_VAL_WIN]   <= VAL_WIN_RST;
			win_q[REG_RED_WIN]   <= RED_WIN_RST;
			win_q[REG_GREEN_WIN] <= GREEN_WIN_RST;
			win_q[REG_BLUE_WIN]  <= BLUE_WIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HUE_WIN:   win_q[REG_HUE_WIN]   <= cfg_data;
				REG_SAT_WIN:   win_q[REG_SAT_WIN]   <= cfg_data;
				REG_VAL_WIN:   win_q[REG_VAL_WIN]   <= cfg_data;
				REG_RED_WIN:   win_q[REG_RED_WIN]   <= cfg_data;
				REG_GREEN_WIN: win_q[REG_GREEN_WIN] <= cfg_data;
				REG_BLUE_WIN:  win_q[REG_BLUE_WIN]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-stage advance: a stage moves when empty or when the next one moves
	assign en_s5    = !v_s5 || m_tready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// stage 1: channel analysis
	rhw_prep u_prep (
		.red   (s_tdata[0 +: CH_W]),
		.green (s_tdata[CH_W +: CH_W]),
		.blue  (s_tdata[2*CH_W +: CH_W]),
		.side  (side_in),
		.diff  (diff_in)
	);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			side_s1 <= side_in;
			diff_s1 <= diff_in;
		end
	end

	// numerators: S uses floor((510*delta + V) / 2) over V,
	// H uses floor((86*diff + delta) / 2) over delta, negatives as ~n
	assign sat_num  = ({side_s1.delta, {CH_W{1'b0}}} - DIV_NUM_W'(side_s1.delta))
		+ DIV_NUM_W'(side_s1.val[CH_W-1:1]);
	assign hue_full = $signed({{(DIV_NUM_W-CH_W-1){diff_s1[CH_W]}}, diff_s1}) * 16'sd86
		+ $signed({{(DIV_NUM_W-CH_W){1'b0}}, side_s1.delta});
	assign hue_half = hue_full >>> 1;
	assign hue_neg  = hue_half[DIV_NUM_W-1];
	assign hue_mag  = hue_neg ? ~hue_half : hue_half;

	// stages 2 to 4: dividers with sideband alongside
	assign div_en.a = en_s2;
	assign div_en.b = en_s3;
	assign div_en.c = en_s4;

	rhw_div u_sat_div (
		.clk (clk),
		.en  (div_en),
		.num (sat_num),
		.den (side_s1.val),
		.quo (sat_quo)
	);

	rhw_div u_hue_div (
		.clk (clk),
		.en  (div_en),
		.num (hue_mag),
		.den (side_s1.delta),
		.quo (hue_quo)
	);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			side_s2 <= side_s1;
			neg_s2  <= hue_neg;
		end
		if (en_s3) begin
			side_s3 <= side_s2;
			neg_s3  <= neg_s2;
		end
		if (en_s4) begin
			side_s4 <= side_s3;
			neg_s4  <= neg_s3;
		end
	end

	// stage 5: hue assembly, gating and output register
	rhw_gate u_gate (
		.side    (side_s4),
		.hue_neg (neg_s4),
		.hue_quo (hue_quo),
		.sat_quo (sat_quo),
		.win     (win_q),
		.hue     (hue_g),
		.sat     (sat_g),
		.reject  (rej_g)
	);

	always_ff @(posedge clk) begin
		if (en_s5) begin
			hue_s5 <= hue_g;
			sat_s5 <= sat_g;
			val_s5 <= side_s4.val;
			rej_s5 <= rej_g;
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = {val_s5, sat_s5, hue_s5};
	assign m_tuser  = rej_s5;

	// a black pixel carries no saturation or hue
	a_black_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[2*CH_W +: CH_W] == '0))
		|-> ((m_tdata[CH_W +: CH_W] == '0) && (m_tdata[0 +: CH_W] == '0)))
		else $error("black pixel with nonzero S or H");

	// a grey pixel carries no hue
	a_grey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[CH_W +: CH_W] == '0)) |-> (m_tdata[0 +: CH_W] == '0))
		else $error("zero saturation with nonzero hue");

	// the input stalls only when every stage is occupied and m_tready is low
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !m_tready))
		else $error("input stalled with a free pipeline slot");

	// a stalled stage keeps its pixel
	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !en_s5) |=> (v_s4 && $stable(side_s4)))
		else $error("stage 4 pixel lost during stall");

endmodule
